### hdl/ccd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the coin change dispenser
// Denomination tables, stock reset counts, reciprocal constants for the
// change division, transaction payload structs and the stock memory request.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int DENOM_SLOTS = 10;
  localparam int NUM_DENOMS  = 10;
  localparam int NUM_ACTIVE  = (NUM_DENOMS > DENOM_SLOTS) ? DENOM_SLOTS : NUM_DENOMS;

  localparam int IDX_W       = $clog2(DENOM_SLOTS);
  localparam int STOCK_W     = 16;
  localparam int COIN_W      = 4;
  localparam int PRICE_W     = 16;
  localparam int MONEY_W     = 19;
  localparam int VALUE_W     = 14;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 24;
  localparam int QUOT_W      = 16;
  localparam int PROD_W      = RECIP_W + MONEY_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACTIVE - 1);

  // Denomination values in cents, smallest first.
  localparam logic [VALUE_W-1:0] DENOM_VALUE [DENOM_SLOTS] = '{
    14'd10, 14'd20, 14'd50, 14'd100, 14'd200,
    14'd500, 14'd1000, 14'd2000, 14'd5000, 14'd10000
  };

  // floor(2^24 / value); the quotient estimate is at most one too small.
  localparam logic [RECIP_W-1:0] DENOM_RECIP [DENOM_SLOTS] = '{
    21'd1677721, 21'd838860, 21'd335544, 21'd167772, 21'd83886,
    21'd33554, 21'd16777, 21'd8388, 21'd3355, 21'd1677
  };

  localparam logic [STOCK_W-1:0] STOCK_RESET [DENOM_SLOTS] = '{
    16'd100, 16'd100, 16'd50, 16'd50, 16'd50,
    16'd25, 16'd25, 16'd25, 16'd25, 16'd10
  };

  typedef struct packed {
    logic [PRICE_W-1:0] price_cents;
    logic [COIN_W-1:0]  coins_10c;
    logic [COIN_W-1:0]  coins_20c;
    logic [COIN_W-1:0]  coins_50c;
    logic [COIN_W-1:0]  coins_1u;
    logic [COIN_W-1:0]  coins_2u;
    logic [COIN_W-1:0]  coins_5u;
    logic [COIN_W-1:0]  coins_10u;
    logic [COIN_W-1:0]  coins_20u;
    logic [COIN_W-1:0]  coins_50u;
    logic [COIN_W-1:0]  coins_100u;
  } purchase_t;

  typedef struct packed {
    logic               status;
    logic [STOCK_W-1:0] give_10c;
    logic [STOCK_W-1:0] give_20c;
    logic [STOCK_W-1:0] give_50c;
    logic [STOCK_W-1:0] give_1u;
    logic [STOCK_W-1:0] give_2u;
    logic [STOCK_W-1:0] give_5u;
    logic [STOCK_W-1:0] give_10u;
    logic [STOCK_W-1:0] give_20u;
    logic [STOCK_W-1:0] give_50u;
    logic [STOCK_W-1:0] give_100u;
    logic [MONEY_W-1:0] unpaid_cents;
  } result_t;

  typedef struct packed {
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [STOCK_W-1:0] wdata;
  } mem_req_t;

endpackage
`default_nettype wire

### hdl/ccd_stock_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_stock_mem: per-denomination coin stock
// One write and one read port, read data registered. An entry that has not
// been written since reset reads as its reset count.
// ----------------------------------------------------------------------------
module ccd_stock_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccd_pkg::mem_req_t             req,
  output logic [ccd_pkg::STOCK_W-1:0]        rdata
);

  logic [ccd_pkg::STOCK_W-1:0]     mem [ccd_pkg::DENOM_SLOTS];
  logic [ccd_pkg::DENOM_SLOTS-1:0] written;
  logic [ccd_pkg::STOCK_W-1:0]     mem_q;
  logic [ccd_pkg::IDX_W-1:0]       addr_q;
  logic                            written_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q  <= mem[req.raddr];
      addr_q <= req.raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        written_q <= written[req.raddr];
      end
    end
  end

  assign rdata = written_q ? mem_q : ccd_pkg::STOCK_RESET[addr_q];

endmodule
`default_nettype wire

### hdl/coin_change_dispenser_core.sv
// From purchase acceptance, the core sums the money over the N active denominations
// in ST_SUM, checks it in ST_CHK, then walks the denominations; a refused purchase
// skips the walk. The greedy walk visits each denomination in ST_RD (stock read),
// ST_MUL (multiplies) and ST_UPD (update and write-back of the stock memory).
// One purchase in flight; a new one is accepted only once the core is back in ST_IDLE.
// Reset restores the reset stock counts at once through per-entry written flags.
`default_nettype none
// ----------------------------------------------------------------------------
// coin_change_dispenser_core: greedy change with limited stock
// Sums the inserted money, refuses a short payment, otherwise adds the
// inserted pieces to stock and pays change from the largest denomination down.
// ----------------------------------------------------------------------------
module coin_change_dispenser_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                purchase_valid,
  output logic                     purchase_ready,
  input  wire ccd_pkg::purchase_t  purchase,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output ccd_pkg::result_t         result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                        state;
  logic [ccd_pkg::IDX_W-1:0]         idx;
  logic [ccd_pkg::PRICE_W-1:0]       price;
  logic [ccd_pkg::COIN_W-1:0]        coins [ccd_pkg::DENOM_SLOTS];
  logic [ccd_pkg::STOCK_W-1:0]       give_cnt [ccd_pkg::DENOM_SLOTS];
  logic [ccd_pkg::MONEY_W-1:0]       money;
  logic [ccd_pkg::MONEY_W-1:0]       change;
  logic [ccd_pkg::PROD_W-1:0]        prod;
  logic [ccd_pkg::QUOT_W-1:0]        quot;
  logic [ccd_pkg::MONEY_W-1:0]       quot_val;
  logic [ccd_pkg::MONEY_W-1:0]       have_val;
  logic [ccd_pkg::STOCK_W-1:0]       have;
  logic                              res_status;

  ccd_pkg::mem_req_t                 mem_req;
  logic [ccd_pkg::STOCK_W-1:0]       stock_rdata;

  logic [ccd_pkg::VALUE_W-1:0]       dval;
  logic [ccd_pkg::STOCK_W:0]         stock_sum;
  logic [ccd_pkg::STOCK_W-1:0]       have_next;
  logic [29:0]                       quot_prod;
  logic [29:0]                       have_prod;
  logic [ccd_pkg::MONEY_W-1:0]       rem;
  logic                              rem_over;
  logic [ccd_pkg::QUOT_W:0]          quot_fix;
  logic                              fits;
  logic [ccd_pkg::STOCK_W-1:0]       give;
  logic [ccd_pkg::MONEY_W-1:0]       change_next;

  ccd_stock_mem u_stock (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (stock_rdata)
  );

  assign purchase_ready = (state == ST_IDLE);

  always_comb begin
    dval      = ccd_pkg::DENOM_VALUE[idx];
    stock_sum = {1'b0, stock_rdata} + (ccd_pkg::STOCK_W + 1)'(coins[idx]);
    have_next = stock_sum[ccd_pkg::STOCK_W] ? '1 : stock_sum[ccd_pkg::STOCK_W-1:0];
    quot_prod = 30'(prod[ccd_pkg::RECIP_SHIFT +: ccd_pkg::QUOT_W]) * 30'(dval);
    have_prod = 30'(have_next) * 30'(dval);
    // The estimate never exceeds the true quotient, so this cannot wrap.
    rem       = change - quot_val;
    rem_over  = (rem >= ccd_pkg::MONEY_W'(dval));
    quot_fix  = (ccd_pkg::QUOT_W + 1)'(quot) + (ccd_pkg::QUOT_W + 1)'(rem_over);
    fits      = (quot_fix <= (ccd_pkg::QUOT_W + 1)'(have));
    give      = fits ? quot_fix[ccd_pkg::QUOT_W-1:0] : have;
    if (fits) begin
      change_next = rem_over ? rem - ccd_pkg::MONEY_W'(dval) : rem;
    end else begin
      change_next = change - have_val;
    end
  end

  always_comb begin
    mem_req       = '0;
    mem_req.raddr = idx;
    mem_req.waddr = idx;
    mem_req.wdata = have - give;
    mem_req.re    = (state == ST_RD);
    mem_req.we    = (state == ST_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (state == ST_DONE && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (purchase_valid) begin
            idx   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (idx == ccd_pkg::LAST_IDX) begin
            state <= ST_CHK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_CHK: begin
          idx   <= ccd_pkg::LAST_IDX;
          state <= (money < ccd_pkg::MONEY_W'(price)) ? ST_DONE : ST_RD;
        end
        ST_RD:  state <= ST_MUL;
        ST_MUL: state <= ST_UPD;
        ST_UPD: begin
          if (idx == '0) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx - 1'b1;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        price     <= purchase.price_cents;
        coins[0]  <= purchase.coins_10c;
        coins[1]  <= purchase.coins_20c;
        coins[2]  <= purchase.coins_50c;
        coins[3]  <= purchase.coins_1u;
        coins[4]  <= purchase.coins_2u;
        coins[5]  <= purchase.coins_5u;
        coins[6]  <= purchase.coins_10u;
        coins[7]  <= purchase.coins_20u;
        coins[8]  <= purchase.coins_50u;
        coins[9]  <= purchase.coins_100u;
        money     <= '0;
        for (int i = 0; i < ccd_pkg::DENOM_SLOTS; i++) begin
          give_cnt[i] <= '0;
        end
      end
      ST_SUM: begin
        money <= money + ccd_pkg::MONEY_W'(coins[idx]) * ccd_pkg::MONEY_W'(dval);
      end
      ST_CHK: begin
        res_status <= (money < ccd_pkg::MONEY_W'(price));
        change     <= (money < ccd_pkg::MONEY_W'(price)) ?
                      '0 : money - ccd_pkg::MONEY_W'(price);
      end
      ST_RD: begin
        prod <= ccd_pkg::PROD_W'(change) * ccd_pkg::PROD_W'(ccd_pkg::DENOM_RECIP[idx]);
      end
      ST_MUL: begin
        have     <= have_next;
        quot     <= prod[ccd_pkg::RECIP_SHIFT +: ccd_pkg::QUOT_W];
        quot_val <= quot_prod[ccd_pkg::MONEY_W-1:0];
        have_val <= have_prod[ccd_pkg::MONEY_W-1:0];
      end
      ST_UPD: begin
        give_cnt[idx] <= give;
        change        <= change_next;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          result.status       <= res_status;
          result.give_10c     <= give_cnt[0];
          result.give_20c     <= give_cnt[1];
          result.give_50c     <= give_cnt[2];
          result.give_1u      <= give_cnt[3];
          result.give_2u      <= give_cnt[4];
          result.give_5u      <= give_cnt[5];
          result.give_10u     <= give_cnt[6];
          result.give_20u     <= give_cnt[7];
          result.give_50u     <= give_cnt[8];
          result.give_100u    <= give_cnt[9];
          result.unpaid_cents <= change;
        end
      end
      default: begin
      end
    endcase
  end

  // The stock memory is never read and written in the same cycle.
  a_mem_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> !mem_req.re)
    else $error("stock read and write in the same cycle");

  // Outstanding change never grows across an update step.
  a_change_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> change <= $past(change))
    else $error("change grew during payout");

  // A result only appears from the completion state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

  // An accepted transaction always starts the money sum.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    purchase_valid && purchase_ready |=> state == ST_SUM && idx == '0)
    else $error("accepted purchase did not start summing");

endmodule
`default_nettype wire
